// ===== rtl/mcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Markov chain sampler package
// Shared widths, command codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int MAX_STATES = 16;
    localparam int PROB_BITS  = 16;

    localparam int STATE_W = $clog2(MAX_STATES);
    localparam int CNT_W   = STATE_W + 1;
    localparam int ADDR_W  = 2 * STATE_W;
    localparam int PROB_W  = PROB_BITS + 1;
    localparam int RAND_W  = PROB_BITS;
    localparam int SUM_W   = PROB_W + STATE_W;
    localparam int CMD_W   = 2;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_BITS;
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_STATES);
    localparam logic [CNT_W-1:0]  CNT_RST  = CNT_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_TRANS = 2'd0,
        CMD_LOAD_INIT  = 2'd1,
        CMD_START      = 2'd2,
        CMD_STEP       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_OUT
    } t_state;

    // Saturate a loaded probability to one.
    function automatic logic [PROB_W-1:0] clamp_prob(input logic [PROB_W-1:0] p);
        return (p > PROB_ONE) ? PROB_ONE : p;
    endfunction

endpackage

// ===== rtl/mcs_if.sv =====
// ----------------------------------------------------------------------------
// Markov chain sampler channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcs_req_if import mcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [STATE_W-1:0]  row;
    logic [STATE_W-1:0]  column;
    logic [PROB_W-1:0]   probability;
    logic [RAND_W-1:0]   random_value;
    logic [STATE_W-1:0]  start_state;
    logic                use_start;

    modport source (output valid, command, row, column, probability, random_value,
                    start_state, use_start, input ready);
    modport sink   (input valid, command, row, column, probability, random_value,
                    start_state, use_start, output ready);
endinterface

interface mcs_rsp_if import mcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATE_W-1:0]  emitted_state;
    logic [STATE_W-1:0]  next_state;
    logic                no_match;

    modport source (output valid, emitted_state, next_state, no_match, input ready);
    modport sink   (input valid, emitted_state, next_state, no_match, output ready);
endinterface

interface mcs_cfg_if import mcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CNT_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/markov_chain_step_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// Markov chain step sampler
// Stores a transition matrix and an initial distribution and samples chain
// states by inverse-CDF walks over one stored row.
// ----------------------------------------------------------------------------
// Usage: load transition entries (command 0) and initial entries (command 1)
// before they are sampled; each load gives no response. A start request
// (command 2) with use_start set takes start_state directly and goes straight
// to the output state; otherwise it, like a step request (command 3), walks
// the first n = min(num_states, 16) entries of one row, reading one entry per
// cycle from the read port of the transition or initial memory. Such a
// request is accepted, issues the first read, adds and compares each entry
// while the next read is issued, sees that no entry matched, and then loads
// the response register; a match ends the walk early, and the load waits
// while the previous response is not yet taken.
// The request channel is ready only while the sequencer is idle, so one
// request is in flight at a time; the response sits in an output register, and
// loads are taken while it waits. The user must write num_states over the
// config channel only while no request is in flight; the block itself does
// not enforce it. Probabilities are Q1.16 with 65536 meaning one; loads above
// one are saturated when stored. A failed sample or an out-of-range explicit
// start raises no_match and keeps the current state.
// ----------------------------------------------------------------------------
module markov_chain_step_sampler_unit import mcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcs_cfg_if.sink   i_cfg,
    mcs_req_if.sink   i_req,
    mcs_rsp_if.source o_rsp
);

    // Storage: transition rows indexed {row, column}, initial entries by column.
    logic [PROB_W-1:0] tp_mem [MAX_STATES*MAX_STATES];
    logic [PROB_W-1:0] ip_mem [MAX_STATES];

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_num_states;
    logic [STATE_W-1:0]  r_cur;
    logic [STATE_W-1:0]  r_emit;
    logic                r_is_step;
    logic                r_use_init;
    logic                r_miss;
    logic [RAND_W-1:0]   r_rand;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_issue;     // entries whose read has been issued
    logic [CNT_W-1:0]    r_chk;       // entries already added and compared
    logic                r_pend;      // read data of entry r_chk is valid
    logic [PROB_W-1:0]   r_tp_rd;
    logic [PROB_W-1:0]   r_ip_rd;

    logic                r_out_vld;
    logic [STATE_W-1:0]  r_out_emit;
    logic [STATE_W-1:0]  r_out_next;
    logic                r_out_miss;

    logic [CNT_W-1:0]    n_act;
    logic                req_acc;
    t_cmd                req_cmd;
    logic [PROB_W-1:0]   rd_data;
    logic [SUM_W-1:0]    sum_next;
    logic                issue_en;
    logic                hit;
    logic                walk_done;
    logic                out_load;
    logic                walk_start;
    logic                start_ok;

    // Effective state count, saturated at the table size.
    assign n_act   = (r_num_states > CNT_MAX) ? CNT_MAX : r_num_states;
    assign req_cmd = t_cmd'(i_req.command);
    assign req_acc = i_req.valid && i_req.ready;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= CNT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_num_states <= i_cfg.data;
        end
    end

    // ---------------- memories ----------------
    // Write on load requests; read every cycle at the walk pointer.
    always_ff @(posedge i_clk) begin
        if (req_acc && req_cmd == CMD_LOAD_TRANS) begin
            tp_mem[{i_req.row, i_req.column}] <= clamp_prob(i_req.probability);
        end
        r_tp_rd <= tp_mem[{r_cur, r_issue[STATE_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (req_acc && req_cmd == CMD_LOAD_INIT) begin
            ip_mem[i_req.column] <= clamp_prob(i_req.probability);
        end
        r_ip_rd <= ip_mem[r_issue[STATE_W-1:0]];
    end

    // ---------------- shared accumulate and compare ----------------
    assign rd_data   = r_use_init ? r_ip_rd : r_tp_rd;
    assign sum_next  = r_sum + SUM_W'(rd_data);
    assign start_ok  = CNT_W'(i_req.start_state) < n_act;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc && req_cmd == CMD_START && i_req.use_start) begin
                    n_state = S_OUT;
                end else if (req_acc && (req_cmd == CMD_START || req_cmd == CMD_STEP)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        i_req.ready = 1'b0;
        issue_en    = 1'b0;
        hit         = 1'b0;
        walk_done   = 1'b0;
        out_load    = 1'b0;
        walk_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                walk_start  = i_req.valid && !(req_cmd == CMD_START && i_req.use_start)
                              && (req_cmd == CMD_START || req_cmd == CMD_STEP);
            end
            S_WALK: begin
                issue_en  = r_issue < n_act;
                hit       = r_pend && ({{(SUM_W-RAND_W){1'b0}}, r_rand} <= sum_next);
                walk_done = hit || (!r_pend && !issue_en);
            end
            S_OUT: begin
                out_load = !r_out_vld || o_rsp.ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- walk datapath ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_miss    <= 1'b0;
            r_is_step <= 1'b0;
            r_use_init <= 1'b0;
            r_issue   <= '0;
            r_chk     <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (req_acc && req_cmd == CMD_START) begin
                r_is_step  <= 1'b0;
                r_use_init <= 1'b1;
                if (i_req.use_start) begin
                    // Explicit start: take it if in range, else flag and hold.
                    r_miss <= !start_ok;
                    if (start_ok) begin
                        r_cur <= i_req.start_state;
                    end
                end
            end
            if (req_acc && req_cmd == CMD_STEP) begin
                r_is_step  <= 1'b1;
                r_use_init <= 1'b0;
                r_emit     <= r_cur;
            end
            if (walk_start) begin
                r_issue <= '0;
                r_chk   <= '0;
                r_pend  <= 1'b0;
                r_sum   <= '0;
                r_rand  <= i_req.random_value;
            end
            if (r_state == S_WALK) begin
                // Issue the next read while the previous entry is compared.
                if (issue_en) begin
                    r_issue <= r_issue + CNT_W'(1);
                end
                r_pend <= issue_en;
                if (r_pend) begin
                    r_sum <= sum_next;
                    r_chk <= r_chk + CNT_W'(1);
                end
                if (hit) begin
                    r_cur  <= r_chk[STATE_W-1:0];
                    r_miss <= 1'b0;
                end else if (walk_done) begin
                    r_miss <= 1'b1;
                end
            end
        end
    end

    // ---------------- response register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_emit <= r_is_step ? r_emit : r_cur;
            r_out_next <= r_cur;
            r_out_miss <= r_miss;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.emitted_state = r_out_emit;
    assign o_rsp.next_state    = r_out_next;
    assign o_rsp.no_match      = r_out_miss;

    // ---------------- assertions ----------------
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_issue <= n_act))
        else $error("walk issued beyond the state count");

    a_chk_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_chk <= r_issue))
        else $error("walk compared an entry that was never read");

    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> (r_chk < n_act))
        else $error("sample picked an index beyond the state count");

    a_rsp_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_OUT))
        else $error("response raised outside the output state");

endmodule

// ===== dv/markov_chain_step_sampler_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Markov chain step sampler testbench
// Loads transition rows and initial distributions, starts and steps the chain
// under state counts from zero to beyond the maximum, and checks each response
// against an in-bench inverse-CDF sampler while both channels idle at random.
// ----------------------------------------------------------------------------
module markov_chain_step_sampler_unit_test;
    import mcs_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int PROB_FULL       = 1 << PROB_BITS;
    localparam int REPORT_LIMIT    = 10;

    // State count written at the head of each phase; phase 0 keeps the reset value.
    localparam int STATE_COUNTS [PHASES] = '{1, 4, 16, 0, 17, 3, 31, 9, 2, 16};

    typedef struct {
        t_cmd               command;
        logic [STATE_W-1:0] row;
        logic [STATE_W-1:0] column;
        logic [PROB_W-1:0]  probability;
        logic [RAND_W-1:0]  random_value;
        logic [STATE_W-1:0] start_state;
        logic               use_start;
    } t_chain_request;

    typedef struct packed {
        logic [STATE_W-1:0] emitted_state;
        logic [STATE_W-1:0] next_state;
        logic               no_match;
    } t_chain_sample;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mcs_cfg_if cfg_ch ();
    mcs_req_if req_ch ();
    mcs_rsp_if rsp_ch ();

    markov_chain_step_sampler_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Sampler state as the bench sees it, advanced on every accepted request
    // ------------------------------------------------------------------------
    logic [PROB_W-1:0]  chain_trans [MAX_STATES*MAX_STATES];
    logic [PROB_W-1:0]  chain_init  [MAX_STATES];
    logic [STATE_W-1:0] chain_state;
    logic [CNT_W-1:0]   chain_count;

    t_chain_sample      expected_samples [$];
    t_chain_request     pending_requests [$];

    // Stimulus side bookkeeping: which entries hold a value, so that no walk
    // ever touches an entry that was never loaded.
    bit                 trans_loaded [MAX_STATES*MAX_STATES];
    bit                 init_loaded  [MAX_STATES];
    int                 walk_len       = 1;  // effective count of the phase being built
    int                 reachable_rows = 1;  // rows that may hold the current state

    t_chain_request     in_flight;
    bit                 req_holding;
    int                 sender_idle_pct;
    int                 receiver_stall_pct;
    int                 sample_errors;
    int                 idle_cycles;
    t_chain_sample      oldest;

    // Add up one row in index order; take the first index whose running sum
    // reaches the target.
    function automatic bit walk_cdf(input bit from_init, input logic [STATE_W-1:0] row,
                                    input logic [RAND_W-1:0] target,
                                    output logic [STATE_W-1:0] pick);
        int          n;
        int unsigned sum;
        n    = (chain_count > CNT_MAX) ? MAX_STATES : int'(chain_count);
        sum  = 0;
        pick = '0;
        for (int i = 0; i < n; i++) begin
            sum += from_init ? chain_init[i] : chain_trans[row*MAX_STATES + i];
            if (target <= sum) begin
                pick = STATE_W'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one accepted request; starts and steps leave one expected sample.
    function automatic void advance_chain(input t_chain_request q);
        t_chain_sample      s;
        logic [STATE_W-1:0] pick;
        int                 n;
        n          = (chain_count > CNT_MAX) ? MAX_STATES : int'(chain_count);
        s.no_match = 1'b0;
        case (q.command)
            CMD_LOAD_TRANS: begin
                // saturate anything above one
                chain_trans[{q.row, q.column}] =
                    (q.probability > PROB_ONE) ? PROB_ONE : q.probability;
                return;
            end
            CMD_LOAD_INIT: begin
                chain_init[q.column] = (q.probability > PROB_ONE) ? PROB_ONE : q.probability;
                return;
            end
            CMD_START: begin
                // an invalid start or a failed sample keeps the current state
                if (q.use_start) begin
                    if (q.start_state < n) chain_state = q.start_state;
                    else s.no_match = 1'b1;
                end else if (walk_cdf(1'b1, '0, q.random_value, pick)) begin
                    chain_state = pick;
                end else begin
                    s.no_match = 1'b1;
                end
                s.emitted_state = chain_state;
            end
            default: begin
                // a step reports the state it leaves, even when no index matches;
                // a state beyond the count still walks its own row
                s.emitted_state = chain_state;
                if (walk_cdf(1'b0, chain_state, q.random_value, pick)) chain_state = pick;
                else s.no_match = 1'b1;
            end
        endcase
        s.next_state = chain_state;
        expected_samples = {expected_samples, s};
    endfunction

    // ------------------------------------------------------------------------
    // Request construction
    // ------------------------------------------------------------------------
    // Randomize every field; fields the command does not use stay random too.
    function automatic t_chain_request noise_request(input t_cmd command);
        t_chain_request q;
        q.command      = command;
        q.row          = STATE_W'($urandom);
        q.column       = STATE_W'($urandom);
        q.probability  = PROB_W'($urandom);
        q.random_value = RAND_W'($urandom);
        q.start_state  = STATE_W'($urandom);
        q.use_start    = 1'($urandom);
        return q;
    endfunction

    function automatic void queue_request(input t_chain_request q);
        if (q.command == CMD_LOAD_TRANS) trans_loaded[{q.row, q.column}] = 1'b1;
        if (q.command == CMD_LOAD_INIT) init_loaded[q.column] = 1'b1;
        pending_requests = {pending_requests, q};
    endfunction

    function automatic void queue_fields(input t_cmd command, input int row, input int column,
                                         input int probability, input int target,
                                         input int start_state, input bit use_start);
        t_chain_request q;
        q              = noise_request(command);
        q.row          = STATE_W'(row);
        q.column       = STATE_W'(column);
        q.probability  = PROB_W'(probability);
        q.random_value = RAND_W'(target);
        q.start_state  = STATE_W'(start_state);
        q.use_start    = use_start;
        queue_request(q);
    endfunction

    // Load the first walk_len entries of one row (or of the initial
    // distribution) as a distribution summing to one; with only_missing set,
    // fill only entries never loaded.
    function automatic void load_distribution(input bit from_init, input int row,
                                              input bit only_missing);
        t_chain_request q;
        int unsigned    remaining;
        int unsigned    cap;
        remaining = PROB_FULL;
        for (int c = 0; c < walk_len; c++) begin
            if (only_missing && (from_init ? init_loaded[c] : trans_loaded[row*MAX_STATES + c]))
                continue;
            q        = noise_request(from_init ? CMD_LOAD_INIT : CMD_LOAD_TRANS);
            q.row    = STATE_W'(row);
            q.column = STATE_W'(c);
            cap      = 2 * remaining / (walk_len - c);
            if (cap > remaining) cap = remaining;
            q.probability = (c == walk_len - 1) ? PROB_W'(remaining)
                                                : PROB_W'($urandom_range(0, cap));
            remaining -= q.probability;
            queue_request(q);
        end
    endfunction

    // Mostly starts and steps on loaded rows, with loads mixed in that bend
    // the distributions; whole rows are reloaded now and then.
    function automatic void queue_random_request();
        t_chain_request q;
        int             roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            for (int r = 0; r < reachable_rows; r++) load_distribution(1'b0, r, 1'b1);
            q = noise_request(CMD_STEP);
        end else if (roll < 62) begin
            load_distribution(1'b1, 0, 1'b1);
            q           = noise_request(CMD_START);
            q.use_start = 1'b0;
        end else if (roll < 72) begin
            q           = noise_request(CMD_START);
            q.use_start = 1'b1;
            if (walk_len > 0 && $urandom_range(0, 1))
                q.start_state = STATE_W'($urandom_range(0, walk_len - 1));
        end else if (roll < 80) begin
            load_distribution(roll >= 77, $urandom_range(0, MAX_STATES - 1), 1'b0);
            return;
        end else begin
            q = noise_request(roll < 92 ? CMD_LOAD_TRANS : CMD_LOAD_INIT);
            case ($urandom_range(0, 7))
                0:       q.probability = '0;
                1:       q.probability = PROB_ONE;
                2:       q.probability = PROB_W'($urandom_range(PROB_FULL + 1, (1 << PROB_W) - 1));
                default: q.probability = PROB_W'($urandom_range(0,
                                             PROB_FULL / (walk_len > 0 ? walk_len : 1)));
            endcase
        end
        // push the sample value to its ends now and then
        case ($urandom_range(0, 7))
            0:       q.random_value = '0;
            1:       q.random_value = '1;
            default: ;
        endcase
        queue_request(q);
    endfunction

    // Extremes under the reset count of one: saturation, invalid starts,
    // matches at zero and at the top of the range, and misses.
    function automatic void queue_directed();
        queue_fields(CMD_LOAD_TRANS, 15, 15, (1 << PROB_W) - 1, 0, 0, 1'b0);
        queue_fields(CMD_LOAD_TRANS, 0, 0, 0, 0, 0, 1'b0);
        queue_fields(CMD_LOAD_INIT, 0, 15, 0, 0, 0, 1'b0);
        queue_fields(CMD_LOAD_INIT, 0, 0, PROB_FULL, 0, 0, 1'b0);
        queue_fields(CMD_START, 0, 0, 0, 0, 0, 1'b1);
        queue_fields(CMD_START, 0, 0, 0, 0, 15, 1'b1);
        queue_fields(CMD_STEP, 0, 0, 0, 0, 0, 1'b0);
        queue_fields(CMD_STEP, 0, 0, 0, PROB_FULL - 1, 0, 1'b0);
        queue_fields(CMD_LOAD_TRANS, 0, 0, PROB_FULL, 0, 0, 1'b0);
        queue_fields(CMD_STEP, 0, 0, 0, PROB_FULL - 1, 0, 1'b0);
        queue_fields(CMD_START, 0, 0, 0, 0, 0, 1'b0);
        queue_fields(CMD_START, 0, 0, 0, PROB_FULL - 1, 0, 1'b0);
        queue_fields(CMD_LOAD_INIT, 0, 0, 100, 0, 0, 1'b0);
        queue_fields(CMD_START, 0, 0, 0, PROB_FULL - 1, 0, 1'b0);
        queue_fields(CMD_START, 0, 0, 0, 100, 0, 1'b0);
        queue_fields(CMD_LOAD_INIT, 0, 0, PROB_FULL + 1, 0, 0, 1'b0);
        queue_fields(CMD_LOAD_TRANS, 0, 0, 70000, 0, 0, 1'b0);
        queue_fields(CMD_STEP, 0, 0, 0, PROB_FULL - 1, 0, 1'b0);
    endfunction

    // Hold until every queued request is taken and every sample has come back.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || req_holding || expected_samples.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_state_count(input logic [CNT_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        chain_count = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Request driver: hold valid until taken, then advance the sampler state
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                advance_chain(in_flight);
                req_holding = 1'b0;
            end
            if (!req_holding && pending_requests.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
                in_flight = pending_requests.pop_front();
                req_ch.command      <= in_flight.command;
                req_ch.row          <= in_flight.row;
                req_ch.column       <= in_flight.column;
                req_ch.probability  <= in_flight.probability;
                req_ch.random_value <= in_flight.random_value;
                req_ch.start_state  <= in_flight.start_state;
                req_ch.use_start    <= in_flight.use_start;
                req_holding = 1'b1;
            end
            // one assignment per edge keeps valid high across back-to-back requests
            req_ch.valid <= req_holding;
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor: compare each taken sample with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_samples.size() == 0) begin
                    sample_errors++;
                    if (sample_errors <= REPORT_LIMIT)
                        $display("unexpected sample: emitted %0d next %0d no_match %0b",
                                 rsp_ch.emitted_state, rsp_ch.next_state, rsp_ch.no_match);
                end else begin
                    oldest = expected_samples.pop_front();
                    if (rsp_ch.emitted_state !== oldest.emitted_state ||
                        rsp_ch.next_state !== oldest.next_state ||
                        rsp_ch.no_match !== oldest.no_match) begin
                        sample_errors++;
                        if (sample_errors <= REPORT_LIMIT) begin
                            $write("sample mismatch: expected emitted %0d next %0d no_match %0b, ",
                                   oldest.emitted_state, oldest.next_state, oldest.no_match);
                            $display("got emitted %0d next %0d no_match %0b",
                                     rsp_ch.emitted_state, rsp_ch.next_state, rsp_ch.no_match);
                        end
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: drop the run when no channel moves for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Phases: reset, then a state count per phase written while the block is
    // idle, each phase with its own idling mode
    // ------------------------------------------------------------------------
    initial begin
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_LOAD_TRANS;
        req_ch.row          = '0;
        req_ch.column       = '0;
        req_ch.probability  = '0;
        req_ch.random_value = '0;
        req_ch.start_state  = '0;
        req_ch.use_start    = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        rsp_ch.ready        = 1'b0;
        chain_state         = '0;
        chain_count         = CNT_RST;
        sample_errors       = 0;
        idle_cycles         = 0;
        req_holding         = 1'b0;
        sender_idle_pct     = 0;
        receiver_stall_pct  = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            // no idling, sender idle, receiver stalling, both now and then
            case (p % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
                default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
            endcase
            if (p != 0) begin
                // loads give no sample, so let a possible walk finish first
                wait_drained();
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                write_state_count(CNT_W'(STATE_COUNTS[p]));
            end
            walk_len = (STATE_COUNTS[p] > MAX_STATES) ? MAX_STATES : STATE_COUNTS[p];
            if (walk_len > reachable_rows) reachable_rows = walk_len;
            if (p == 0) queue_directed();
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // pause the sender midway until every sample is back
                if (p % 2 == 1 && k == ITEMS_PER_PHASE / 2) wait_drained();
                queue_random_request();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sample_errors == 0 && expected_samples.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== markov_chain_step_sampler_unit.f =====
rtl/mcs_pkg.sv
rtl/mcs_if.sv
rtl/markov_chain_step_sampler_unit.sv
dv/markov_chain_step_sampler_unit_test.sv
